FILE: sv/framebuffer_rect_engine_assert.svh
// Assertion macros shared by the rectangle engine RTL.
`ifndef FRAMEBUFFER_RECT_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_RECT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FRE_ASSERT_IMP(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rect engine assertion failed");

// Next-cycle implication, disabled while reset is held.
`define FRE_ASSERT_NXT(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rect engine assertion failed");

`endif

FILE: sv/fre_pkg.sv
// Types and constants shared by the rectangle engine modules.
package fre_pkg;

  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int PIX_W   = 24;
  localparam int IDX_W   = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] RESET_PIXEL = 24'hBABABA;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN   = 2'd2;

  typedef enum logic [2:0] {
    CMD_SET   = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_FILL  = 3'd3,
    CMD_CROP  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_FILL,
    OP_CROP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_RECT = 2'd1,
    ST_PAST_END = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] fw;
    status_t          status;
    logic             black;
    logic             written;
  } desc_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    status_t    status;
    logic       black;
    logic       written;
  } res_t;

endpackage

FILE: sv/fre_queue.sv
// Two-entry queue used between the engine stages and at the result side.
module fre_queue #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  import fre_pkg::*;

  T           mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/fre_front.sv
// Front stage: configuration, rectangle checks, cursor, flags and address setup.
module fre_front #(
  parameter int MAX_DIM      = 256,
  parameter int STORE_PIXELS = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fre_pkg::DIM_W-1:0]    cfg_wdata,
  input  logic                         accept,
  input  logic [2:0]                   cmd,
  input  logic [fre_pkg::COORD_W-1:0]  rect_x,
  input  logic [fre_pkg::COORD_W-1:0]  rect_y,
  input  logic [fre_pkg::DIM_W-1:0]    rect_w,
  input  logic [fre_pkg::DIM_W-1:0]    rect_h,
  input  logic [31:0]                  packed_pixel,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,
  output fre_pkg::desc_t               desc
);
  import fre_pkg::*;

  logic [DIM_W-1:0]   fw_r, fh_r;
  logic               be_r;
  logic [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [DIM_W-1:0]   cw_r, cw_nxt, ch_r, ch_nxt;
  logic [DIM_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic               black_r, black_nxt, written_r, written_nxt;

  logic [17:0] area;
  logic        frame_ok, in_ok, cur_ok, cursor_cmd;
  logic [9:0]  mul_a, add_c;
  logic [18:0] prod;
  logic [PIX_W-1:0] fill_pix;
  logic [DIM_W-1:0] col_inc;

  function automatic logic fits(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [DIM_W-1:0] fw, input logic [DIM_W-1:0] fh);
    logic ok;
    ok = (w != '0) && (h != '0) && ((10'(x) + 10'(w)) <= 10'(fw)) &&
         ((10'(y) + 10'(h)) <= 10'(fh));
    return ok;
  endfunction

  always_comb begin
    area     = 18'(fw_r) * 18'(fh_r);
    frame_ok = (fw_r != '0) && (fh_r != '0) && (int'(fw_r) <= MAX_DIM) &&
               (int'(fh_r) <= MAX_DIM) && ({14'd0, area} <= 32'(STORE_PIXELS));
    in_ok    = frame_ok && fits(rect_x, rect_y, rect_w, rect_h, fw_r, fh_r);
    cur_ok   = frame_ok && fits(cx_r, cy_r, cw_r, ch_r, fw_r, fh_r);
    cursor_cmd = (cmd == CMD_WRITE) || (cmd == CMD_READ);
    mul_a    = cursor_cmd ? (10'(cy_r) + 10'(row_r)) : 10'(rect_y);
    add_c    = cursor_cmd ? (10'(cx_r) + 10'(col_r)) : 10'(rect_x);
    prod     = 19'(mul_a) * 19'(fw_r);
    if (be_r) begin
      fill_pix = {packed_pixel[31:24], packed_pixel[23:16], packed_pixel[15:8]};
    end else begin
      fill_pix = {packed_pixel[7:0], packed_pixel[15:8], packed_pixel[23:16]};
    end
    col_inc = col_r + 9'd1;
  end

  always_comb begin
    cx_nxt = cx_r;  cy_nxt = cy_r;  cw_nxt = cw_r;  ch_nxt = ch_r;
    col_nxt = col_r;  row_nxt = row_r;
    black_nxt = black_r;  written_nxt = written_r;
    desc.op     = OP_NONE;
    desc.idx    = IDX_W'(prod) + IDX_W'(add_c);
    desc.pix    = fill_pix;
    desc.w      = rect_w;
    desc.h      = rect_h;
    desc.fw     = fw_r;
    desc.status = ST_OK;
    case (cmd)
      CMD_SET: begin
        if (in_ok) begin
          cx_nxt = rect_x;  cy_nxt = rect_y;  cw_nxt = rect_w;  ch_nxt = rect_h;
          col_nxt = '0;  row_nxt = '0;
        end else begin
          desc.status = ST_BAD_RECT;
        end
      end
      CMD_WRITE, CMD_READ: begin
        if (!cur_ok) begin
          desc.status = ST_BAD_RECT;
        end else if (row_r >= ch_r) begin
          desc.status = ST_PAST_END;
        end else begin
          if (col_inc >= cw_r) begin
            col_nxt = '0;
            row_nxt = row_r + 9'd1;
          end else begin
            col_nxt = col_inc;
          end
          if (cmd == CMD_WRITE) begin
            desc.op     = OP_WRITE;
            desc.pix    = {red, green, blue};
            written_nxt = 1'b1;
            if ((red | green | blue) != 8'd0) begin
              black_nxt = 1'b0;
            end
          end else begin
            desc.op = OP_READ;
          end
        end
      end
      CMD_FILL: begin
        if (!in_ok) begin
          desc.status = ST_BAD_RECT;
        end else begin
          desc.op     = OP_FILL;
          written_nxt = 1'b1;
          if (fill_pix != '0) begin
            black_nxt = 1'b0;
          end
        end
      end
      CMD_CROP: begin
        if (!in_ok) begin
          desc.status = ST_BAD_RECT;
        end else if (!(rect_x == '0 && rect_y == '0 && rect_w == fw_r)) begin
          desc.op = OP_CROP;
        end
      end
      default: begin
      end
    endcase
    desc.black   = black_nxt;
    desc.written = written_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 9'd256;  fh_r <= 9'd256;  be_r <= 1'b0;
      cx_r <= '0;  cy_r <= '0;  cw_r <= 9'd1;  ch_r <= 9'd1;
      col_r <= '0;  row_r <= '0;
      black_r <= 1'b1;  written_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
          CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
          CFG_BIG_ENDIAN:   be_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        cx_r <= cx_nxt;  cy_r <= cy_nxt;  cw_r <= cw_nxt;  ch_r <= ch_nxt;
        col_r <= col_nxt;  row_r <= row_nxt;
        black_r <= black_nxt;  written_r <= written_nxt;
      end
    end
  end

endmodule

FILE: sv/fre_back.sv
// Back stage: pixel store, clearing pass, and execution of store operations.
module fre_back #(
  parameter int STORE_PIXELS = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fre_pkg::desc_t desc,
  input  logic           desc_empty,
  output logic           desc_pop,
  input  logic           res_full,
  output logic           res_push,
  output fre_pkg::res_t  res,
  output logic           clearing
);
  import fre_pkg::*;

  localparam int AW = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_FILL, S_CROP_RD, S_CROP_WR, S_DONE
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    clr_r;
  logic [IDX_W-1:0] base_r, dst_r;
  logic [DIM_W-1:0] col_r, row_r;
  desc_t            cur_r;
  logic [PIX_W-1:0] mem [STORE_PIXELS];
  logic [PIX_W-1:0] rd_r;

  logic             we, re, last, row_end;
  logic [AW-1:0]    wa, ra;
  logic [PIX_W-1:0] wd;
  logic [IDX_W-1:0] src;

  assign clearing = (state_r == S_CLEAR);
  assign src      = base_r + IDX_W'(col_r);
  assign row_end  = (col_r == cur_r.w - 9'd1);
  assign last     = row_end && (row_r == cur_r.h - 9'd1);

  always_comb begin
    desc_pop = 1'b0;
    res_push = 1'b0;
    we = 1'b0;  re = 1'b0;
    wa = AW'(src);  ra = AW'(src);  wd = cur_r.pix;
    res.red = '0;  res.green = '0;  res.blue = '0;
    res.status  = cur_r.status;
    res.black   = cur_r.black;
    res.written = cur_r.written;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;  wa = clr_r;  wd = RESET_PIXEL;
      end
      S_IDLE: begin
        res.status  = desc.status;
        res.black   = desc.black;
        res.written = desc.written;
        if (!desc_empty && !res_full) begin
          desc_pop = 1'b1;
          case (desc.op)
            OP_WRITE: begin
              we = 1'b1;  wa = AW'(desc.idx);  wd = desc.pix;  res_push = 1'b1;
            end
            OP_READ: begin
              re = 1'b1;  ra = AW'(desc.idx);
            end
            OP_FILL, OP_CROP: begin
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      S_READ: begin
        res_push  = 1'b1;
        res.red   = rd_r[23:16];
        res.green = rd_r[15:8];
        res.blue  = rd_r[7:0];
      end
      S_FILL:    we = 1'b1;
      S_CROP_RD: re = 1'b1;
      S_CROP_WR: begin
        we = 1'b1;  wa = AW'(dst_r);  wd = rd_r;
      end
      S_DONE:    res_push = !res_full;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(STORE_PIXELS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (desc_pop) begin
            cur_r  <= desc;
            base_r <= desc.idx;
            col_r  <= '0;
            row_r  <= '0;
            dst_r  <= '0;
            case (desc.op)
              OP_READ: state_r <= S_READ;
              OP_FILL: state_r <= S_FILL;
              OP_CROP: state_r <= S_CROP_RD;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_READ: state_r <= S_IDLE;
        S_FILL, S_CROP_WR: begin
          if (state_r == S_CROP_WR) begin
            dst_r <= dst_r + IDX_W'(1);
          end
          if (row_end) begin
            col_r  <= '0;
            row_r  <= row_r + 9'd1;
            base_r <= base_r + IDX_W'(cur_r.fw);
          end else begin
            col_r <= col_r + 9'd1;
          end
          if (last) begin
            state_r <= S_DONE;
          end else if (state_r == S_CROP_WR) begin
            state_r <= S_CROP_RD;
          end
        end
        S_CROP_RD: state_r <= S_CROP_WR;
        S_DONE: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

endmodule

FILE: sv/framebuffer_rect_engine.sv
// Top level of the rectangle engine over a 24-bit RGB pixel store.
// Usage: commands enter through a queue-like port (push/full) and every command
// produces exactly one result transaction, read through empty/pop in command order.
// Configuration (frame width, frame height, endian mode) is written through
// cfg_we/cfg_index/cfg_wdata while no command is in flight; writes take effect at once.
// After reset the block runs a clearing pass that sets every pixel to 0xBABABA;
// it covers all STORE_PIXELS entries (65536 by default) and full stays high meanwhile.
// The front stage checks and classifies a command in the cycle it is accepted
// and hands a descriptor to a two-entry queue; the back stage owns the store.
// Fill and crop hold the back stage until done: the store takes one pixel write a
// cycle, and a crop copy needs a read (S_CROP_RD) and a write (S_CROP_WR) per pixel.
// The back stage takes one command a cycle for writes and non-store commands while
// the result queue has room; a read passes through S_READ before the next is taken.
// A stalled receiver fills the result queue, then the descriptor queue, after which
// full rises and commands wait upstream.
module framebuffer_rect_engine #(
  parameter int MAX_DIM      = 256,
  parameter int STORE_PIXELS = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [2:0]                    in_cmd,
  input  logic [fre_pkg::COORD_W-1:0]   in_rect_x,
  input  logic [fre_pkg::COORD_W-1:0]   in_rect_y,
  input  logic [fre_pkg::DIM_W-1:0]     in_rect_w,
  input  logic [fre_pkg::DIM_W-1:0]     in_rect_h,
  input  logic [31:0]                   in_packed_pixel,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [1:0]                    out_status,
  output logic                          out_all_black,
  output logic                          out_ever_written,
  input  logic                          cfg_we,
  input  logic [fre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fre_pkg::DIM_W-1:0]     cfg_wdata
);
  import fre_pkg::*;
  `include "framebuffer_rect_engine_assert.svh"

  desc_t front_desc, back_desc;
  res_t  back_res, out_res;
  logic  desc_full, desc_empty, desc_pop;
  logic  res_full, res_push;
  logic  clearing, accept;

  // The store is not usable until the clearing pass is over.
  assign full   = desc_full || clearing;
  assign accept = push && !full;

  fre_front #(
    .MAX_DIM      (MAX_DIM),
    .STORE_PIXELS (STORE_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .cmd          (in_cmd),
    .rect_x       (in_rect_x),
    .rect_y       (in_rect_y),
    .rect_w       (in_rect_w),
    .rect_h       (in_rect_h),
    .packed_pixel (in_packed_pixel),
    .red          (in_red),
    .green        (in_green),
    .blue         (in_blue),
    .desc         (front_desc)
  );

  fre_queue #(.T(desc_t)) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_desc),
    .full  (desc_full),
    .pop   (desc_pop),
    .rdata (back_desc),
    .empty (desc_empty)
  );

  fre_back #(.STORE_PIXELS(STORE_PIXELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (back_desc),
    .desc_empty (desc_empty),
    .desc_pop   (desc_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res),
    .clearing   (clearing)
  );

  fre_queue #(.T(res_t)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_red          = out_res.red;
  assign out_green        = out_res.green;
  assign out_blue         = out_res.blue;
  assign out_status       = out_res.status;
  assign out_all_black    = out_res.black;
  assign out_ever_written = out_res.written;

  // The back stage only produces a result when the result queue has room.
  `FRE_ASSERT_IMP(a_res_room, clk, rst_n, res_push, !res_full)
  // A result pushed is visible on the output side in the next cycle.
  `FRE_ASSERT_NXT(a_res_visible, clk, rst_n, res_push, !empty)
  // Nothing can be in flight while the store is being cleared.
  `FRE_ASSERT_IMP(a_clear_quiet, clk, rst_n, clearing, desc_empty && empty)

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the rectangle engine: a scoreboard predicts every result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fre_pkg::*;

  // Codes 5 through 7 are not commands; the block must answer them with an ok status.
  localparam logic [2:0] CMD_LAST_CODE = 3'd7;
  localparam int STORE_SIZE = 65536;
  localparam int MAX_SIDE = 256;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [31:0] color;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } cmd_item_t;

  // The scoreboard keeps its own copy of the pixel store, the rectangle, the cursor,
  // the flags and the registers, and queues one expected result per command.
  class rect_scoreboard;
    logic [23:0] pixels [STORE_SIZE];
    int unsigned fw, fh;
    bit big_end;
    int unsigned rx, ry, rw, rh, ccol, crow;
    bit black, written;
    res_t pending_q[$];
    int mismatches;

    function new();
      foreach (pixels[i]) pixels[i] = RESET_PIXEL;
      fw = MAX_SIDE;
      fh = MAX_SIDE;
      big_end = 1'b0;
      rx = 0;
      ry = 0;
      rw = 1;
      rh = 1;
      ccol = 0;
      crow = 0;
      black = 1'b1;
      written = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  fw = val;
        CFG_FRAME_HEIGHT: fh = val;
        CFG_BIG_ENDIAN:   big_end = val[0];
        default: ;
      endcase
    endfunction

    function bit rect_fits(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
      if (fw < 1 || fw > MAX_SIDE || fh < 1 || fh > MAX_SIDE) return 1'b0;
      if (fw * fh > STORE_SIZE) return 1'b0;
      if (w == 0 || h == 0) return 1'b0;
      if (x + w > fw || y + h > fh) return 1'b0;
      return 1'b1;
    endfunction

    // Works out the result of one accepted command and applies its side effects.
    function void note_command(cmd_item_t it);
      res_t res;
      int unsigned idx, dst;
      logic [23:0] color;
      res = '0;
      res.status = ST_OK;
      if (it.cmd == CMD_SET) begin
        if (rect_fits(it.x, it.y, it.w, it.h)) begin
          rx = it.x;
          ry = it.y;
          rw = it.w;
          rh = it.h;
          ccol = 0;
          crow = 0;
        end else begin
          res.status = ST_BAD_RECT;
        end
      end else if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
        if (!rect_fits(rx, ry, rw, rh)) begin
          res.status = ST_BAD_RECT;
        end else if (crow >= rh) begin
          res.status = ST_PAST_END;
        end else begin
          idx = ((ry + crow) * fw + rx + ccol) % STORE_SIZE;
          if (it.cmd == CMD_WRITE) begin
            pixels[idx] = {it.r, it.g, it.b};
            written = 1'b1;
            if ({it.r, it.g, it.b} != 24'd0) black = 1'b0;
          end else begin
            {res.red, res.green, res.blue} = pixels[idx];
          end
          ccol++;
          if (ccol >= rw) begin
            ccol = 0;
            crow++;
          end
        end
      end else if (it.cmd == CMD_FILL) begin
        if (!rect_fits(it.x, it.y, it.w, it.h)) begin
          res.status = ST_BAD_RECT;
        end else begin
          // The endian mode picks which bytes of the packed word hold red, green, blue.
          color = big_end ? it.color[31:8] : {it.color[7:0], it.color[15:8], it.color[23:16]};
          written = 1'b1;
          if (color != 24'd0) black = 1'b0;
          for (int unsigned row = 0; row < it.h; row++)
            for (int unsigned col = 0; col < it.w; col++)
              pixels[((it.y + row) * fw + it.x + col) % STORE_SIZE] = color;
        end
      end else if (it.cmd == CMD_CROP) begin
        if (!rect_fits(it.x, it.y, it.w, it.h)) begin
          res.status = ST_BAD_RECT;
        end else if (!(it.x == 0 && it.y == 0 && it.w == fw)) begin
          // The copy runs in raster order over the live store, overlaps included.
          dst = 0;
          for (int unsigned row = 0; row < it.h; row++)
            for (int unsigned col = 0; col < it.w; col++) begin
              pixels[dst % STORE_SIZE] = pixels[((it.y + row) * fw + it.x + col) % STORE_SIZE];
              dst++;
            end
        end
      end
      res.black = black;
      res.written = written;
      pending_q.push_back(res);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no command waiting: rgb %h%h%h status %0d",
                   got.red, got.green, got.blue, got.status);
        return;
      end
      want = pending_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.status !== want.status || got.black !== want.black ||
          got.written !== want.written) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result differs: expected rgb %h%h%h st %0d blk %b wr %b, got rgb %h%h%h st %0d blk %b wr %b",
                   want.red, want.green, want.blue, want.status, want.black, want.written,
                   got.red, got.green, got.blue, got.status, got.black, got.written);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic [2:0] in_cmd;
  logic [COORD_W-1:0] in_rect_x, in_rect_y;
  logic [DIM_W-1:0] in_rect_w, in_rect_h;
  logic [31:0] in_packed_pixel;
  logic [7:0] in_red, in_green, in_blue;
  logic empty;
  logic pop;
  logic [7:0] out_red, out_green, out_blue;
  logic [1:0] out_status;
  logic out_all_black, out_ever_written;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  rect_scoreboard board;

  // When set, neither side inserts idle cycles.
  bit no_gaps;
  // The main process bumps this to ask the result side for one long hold-off.
  int hold_requests;

  // Frame registers as last written; used to shape random rectangles.
  int unsigned frame_w, frame_h;

  framebuffer_rect_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_cmd(in_cmd),
    .in_rect_x(in_rect_x),
    .in_rect_y(in_rect_y),
    .in_rect_w(in_rect_w),
    .in_rect_h(in_rect_h),
    .in_packed_pixel(in_packed_pixel),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .empty(empty),
    .pop(pop),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_status(out_status),
    .out_all_black(out_all_black),
    .out_ever_written(out_ever_written),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop. The slowest legal run, reset clearing pass and stalls included,
  // stays well inside this bound.
  initial begin
    #50_000_000;
    $display("framebuffer_rect_engine: mismatch");
    $finish;
  end

  // Result side: pops at random, honors hold-off requests, and checks every
  // transaction that completes at a clock edge.
  initial begin
    int holds_done;
    int hold_left;
    res_t got;
    holds_done = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      if (hold_left == 0 && holds_done < hold_requests) begin
        holds_done++;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_gaps ? 1'b1 : ($urandom_range(99) >= 27);
      end
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        got.red = out_red;
        got.green = out_green;
        got.blue = out_blue;
        got.status = status_t'(out_status);
        got.black = out_all_black;
        got.written = out_ever_written;
        board.check_result(got);
      end
    end
  end

  function automatic cmd_item_t make_item(logic [2:0] cmd, int x, int y, int w, int h,
                                          logic [31:0] color, logic [23:0] rgb);
    cmd_item_t it;
    it.cmd = cmd;
    it.x = 8'(x);
    it.y = 8'(y);
    it.w = 9'(w);
    it.h = 9'(h);
    it.color = color;
    {it.r, it.g, it.b} = rgb;
    return it;
  endfunction

  // Random command. Most rectangles fit the frame and stay small so that fill
  // and crop remain cheap; a few are raw random bits or span the whole frame.
  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int unsigned pick, lim_w, lim_h;
    pick = $urandom_range(99);
    if (pick < 15) it.cmd = CMD_SET;
    else if (pick < 50) it.cmd = CMD_WRITE;
    else if (pick < 80) it.cmd = CMD_READ;
    else if (pick < 89) it.cmd = CMD_FILL;
    else if (pick < 95) it.cmd = CMD_CROP;
    else it.cmd = 3'($urandom_range(CMD_CROP + 1, CMD_LAST_CODE));
    it.color = $urandom();
    it.r = 8'($urandom());
    it.g = 8'($urandom());
    it.b = 8'($urandom());
    if ($urandom_range(9) == 0) begin
      {it.r, it.g, it.b} = 24'd0;
      it.color = 32'd0;
    end
    if (frame_w >= 1 && frame_w <= MAX_SIDE && frame_h >= 1 && frame_h <= MAX_SIDE &&
        $urandom_range(19) != 0) begin
      it.x = 8'($urandom_range(frame_w - 1));
      it.y = 8'($urandom_range(frame_h - 1));
      lim_w = frame_w - it.x;
      lim_h = frame_h - it.y;
      if ($urandom_range(49) != 0) begin
        if (lim_w > 12) lim_w = 12;
        if (lim_h > 12) lim_h = 12;
      end else begin
        it.x = 8'd0;
        it.y = 8'd0;
        lim_w = frame_w;
        lim_h = frame_h;
      end
      it.w = 9'($urandom_range(1, lim_w));
      it.h = 9'($urandom_range(1, lim_h));
    end else begin
      it.x = 8'($urandom());
      it.y = 8'($urandom());
      it.w = 9'($urandom());
      it.h = 9'($urandom());
    end
    return it;
  endfunction

  // Offers one command and returns once the block has taken it.
  task automatic send_command(cmd_item_t it);
    while (!no_gaps && $urandom_range(99) < 27) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_cmd <= it.cmd;
    in_rect_x <= it.x;
    in_rect_y <= it.y;
    in_rect_w <= it.w;
    in_rect_h <= it.h;
    in_packed_pixel <= it.color;
    in_red <= it.r;
    in_green <= it.g;
    in_blue <= it.b;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_command(it);
  endtask

  // Stops offering and waits until every expected result has been popped.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers; only called while the block is idle.
  task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, bit be);
    logic [DIM_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0] idxs [3];
    vals = '{w, h, {8'd0, be}};
    idxs = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_BIG_ENDIAN};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.write_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  initial begin
    cmd_item_t directed [$];
    int phase_w [8];
    int phase_h [8];
    bit phase_be [8];
    board = new();
    no_gaps = 1'b0;
    hold_requests = 0;
    frame_w = MAX_SIDE;
    frame_h = MAX_SIDE;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_cmd <= CMD_SET;
    in_rect_x <= '0;
    in_rect_y <= '0;
    in_rect_w <= '0;
    in_rect_h <= '0;
    in_packed_pixel <= '0;
    in_red <= '0;
    in_green <= '0;
    in_blue <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands under the reset frame: the reset rectangle and store pattern,
    // running past the rectangle end, rejected rectangles, a full-frame black fill,
    // corner fills, the crop that is skipped at full width, unused codes.
    directed.push_back(make_item(CMD_READ, 0, 0, 1, 1, 0, 24'h0));
    directed.push_back(make_item(CMD_READ, 0, 0, 1, 1, 0, 24'h0));
    directed.push_back(make_item(CMD_WRITE, 0, 0, 1, 1, 0, 24'h123456));
    directed.push_back(make_item(CMD_SET, 0, 0, 0, 5, 0, 24'h0));
    directed.push_back(make_item(CMD_SET, 255, 0, 2, 1, 0, 24'h0));
    directed.push_back(make_item(CMD_SET, 0, 0, 256, 256, 0, 24'h0));
    directed.push_back(make_item(CMD_WRITE, 0, 0, 0, 0, 0, 24'h000000));
    directed.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 24'h0));
    directed.push_back(make_item(CMD_FILL, 0, 0, 256, 256, 32'h0, 24'h0));
    directed.push_back(make_item(CMD_FILL, 250, 250, 6, 6, 32'hFFFFFFFF, 24'h0));
    directed.push_back(make_item(CMD_FILL, 255, 255, 1, 1, 32'h00123456, 24'h0));
    directed.push_back(make_item(CMD_CROP, 0, 0, 256, 4, 0, 24'h0));
    directed.push_back(make_item(CMD_CROP, 248, 249, 8, 7, 0, 24'h0));
    directed.push_back(make_item(CMD_SET, 0, 0, 4, 2, 0, 24'h0));
    for (int i = 0; i < 4; i++) directed.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 24'h0));
    for (int c = CMD_CROP + 1; c <= CMD_LAST_CODE; c++)
      directed.push_back(make_item(3'(c), 0, 0, 1, 1, 0, 24'h0));
    directed.push_back(make_item(CMD_FILL, 0, 0, 257, 1, 32'h1, 24'h0));
    directed.push_back(make_item(CMD_FILL, 1, 1, 0, 0, 32'h1, 24'h0));
    directed.push_back(make_item(CMD_CROP, 0, 0, 511, 511, 0, 24'h0));
    directed.push_back(make_item(CMD_WRITE, 0, 0, 0, 0, 0, 24'hFFFFFF));
    foreach (directed[i]) send_command(directed[i]);
    drain();

    // Register settings per phase: the extremes, a tall narrow frame, big-endian
    // fills, and frames that are out of range so that every rectangle command is rejected.
    phase_w = '{256, 16, 1, 7, 256, 0, 300, 12};
    phase_h = '{256, 16, 1, 200, 3, 9, 256, 12};
    phase_be = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    for (int p = 0; p < 8; p++) begin
      set_frame(9'(phase_w[p]), 9'(phase_h[p]), phase_be[p]);
      no_gaps = (p == 1);
      // One long receiver hold-off while commands keep coming, so full rises.
      if (p == 3) hold_requests++;
      for (int n = 0; n < 128; n++) send_command(random_item());
      drain();
    end

    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("framebuffer_rect_engine: match");
    end else begin
      $display("framebuffer_rect_engine: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/fre_pkg.sv
sv/fre_queue.sv
sv/fre_front.sv
sv/fre_back.sv
sv/framebuffer_rect_engine.sv
dv/tb.sv
